// ----- rtl/nonpreemptive_priority_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_defines
// Assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// Field widths, job record type and helpers for the priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int NUM_W  = 5;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
  } job_rec_t;

  // Controls from the sequencer to the selection unit
  typedef struct packed {
    logic clear;   // start of a new scan
    logic sample;  // a record is on the read data bus
    logic skip;    // that record's job is already finished
  } pick_ctl_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] v);
    return v[TIME_W] ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] v);
    return v[SUM_W] ? SUM_MAX : v[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/nps_in_if.sv -----
// ----------------------------------------------------------------------------
// nps_in_if
// Job record channel: valid/ready handshake with the record fields.
// ----------------------------------------------------------------------------
interface nps_in_if
  import nps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] arrival_time;
  logic [BUR_W-1:0] burst_time;
  logic [PRI_W-1:0] priority_level;
  logic             last_entry;

  modport source (
    output valid, arrival_time, burst_time, priority_level, last_entry,
    input  ready
  );
  modport sink (
    input  valid, arrival_time, burst_time, priority_level, last_entry,
    output ready
  );
endinterface

// ----- rtl/nps_out_if.sv -----
// ----------------------------------------------------------------------------
// nps_out_if
// Completed job channel: valid/ready handshake with timing fields.
// ----------------------------------------------------------------------------
interface nps_out_if
  import nps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NUM_W-1:0]  job_number;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] wait_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [SUM_W-1:0]  total_wait;
  logic [SUM_W-1:0]  total_turnaround;
  logic              final_result;

  modport source (
    output valid, job_number, start_time, wait_time, turnaround_time,
           total_wait, total_turnaround, final_result,
    input  ready
  );
  modport sink (
    input  valid, job_number, start_time, wait_time, turnaround_time,
           total_wait, total_turnaround, final_result,
    output ready
  );
endinterface

// ----- rtl/nps_job_mem.sv -----
// ----------------------------------------------------------------------------
// nps_job_mem
// Job record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nps_job_mem
  import nps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  job_rec_t      wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output job_rec_t      rd_data
);

  job_rec_t mem [DEPTH];
  job_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/nps_picker.sv -----
// ----------------------------------------------------------------------------
// nps_picker
// Running selection over the record stream of one scan: best ready job
// (priority, then arrival, then index) and earliest unfinished arrival.
// ----------------------------------------------------------------------------
module nps_picker
  import nps_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pick_ctl_t         ctl,
  input  logic [TIME_W-1:0] clock_now,
  input  job_rec_t          rec,
  input  logic [IDX_W-1:0]  idx,
  output logic              found,
  output job_rec_t          best_rec,
  output logic [IDX_W-1:0]  best_idx,
  output logic [ARR_W-1:0]  earliest
);

  logic             found_r;
  job_rec_t         best_rec_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [ARR_W-1:0] earliest_r;
  logic             ready_job;
  logic             better;
  logic             take;

  assign ready_job = TIME_W'(rec.arrival) <= clock_now;
  // Scan runs in index order, so equal keys keep the earlier index
  assign better = (rec.prio < best_rec_r.prio) ||
                  ((rec.prio == best_rec_r.prio) &&
                   (rec.arrival < best_rec_r.arrival));
  assign take = ctl.sample && !ctl.skip && ready_job && (!found_r || better);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      earliest_r <= '1;
    end else if (ctl.sample && !ctl.skip && (rec.arrival < earliest_r)) begin
      earliest_r <= rec.arrival;
    end
    if (take) begin
      best_rec_r <= rec;
      best_idx_r <= idx;
    end
  end

  assign found    = found_r;
  assign best_rec = best_rec_r;
  assign best_idx = best_idx_r;
  assign earliest = earliest_r;

endmodule

// ----- rtl/nonpreemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// A job record is taken on each handshake while idle; the marked record starts the run.
// Each decision scans the record memory: one read per loaded job, one read per
//   cycle, then the registered read data drains into the picker and it decides.
// Each completed job takes a scan, the time calc and the emit; every idle gap
//   that forces a jump to the next arrival adds another scan.
// Reset (synchronous, rst_n low) empties the batch; the memory is not cleared.
// ----------------------------------------------------------------------------
`include "nonpreemptive_priority_scheduler_defines.svh"

module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  nps_in_if.sink    in_job,
  nps_out_if.source out_job
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // taking job records
    ST_SCAN = 4'b0010,  // streaming the records through the picker
    ST_CALC = 4'b0100,  // wait time and next clock for the chosen job
    ST_EMIT = 4'b1000   // hand the result to the output register
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;       // jobs loaded in this batch
  logic [CNT_W-1:0]  emitted_r;   // jobs completed so far
  logic [CNT_W-1:0]  scan_r;      // next read address of the scan
  logic [MAX_JOBS-1:0] done_r;    // finished-job flags
  logic [TIME_W-1:0] clock_r;     // schedule clock
  logic [SUM_W-1:0]  wsum_r;
  logic [SUM_W-1:0]  tsum_r;
  logic              rd_vld_r;    // read data valid
  logic [IDX_W-1:0]  rd_idx_r;    // index of the record on rd_data
  logic [TIME_W-1:0] wait_r;
  logic [TIME_W-1:0] cnext_r;     // clock after the chosen job runs

  // Output register
  logic              out_valid_r;
  logic [NUM_W-1:0]  out_num_r;
  logic [TIME_W-1:0] out_start_r;
  logic [TIME_W-1:0] out_wait_r;
  logic [TIME_W-1:0] out_tat_r;
  logic [SUM_W-1:0]  out_wsum_r;
  logic [SUM_W-1:0]  out_tsum_r;
  logic              out_final_r;

  logic              in_fire;
  logic              load_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              scan_end;
  logic              emit;
  logic              last_job;
  logic [CNT_W-1:0]  emitted_inc;
  logic [IDX_W:0]    num_inc;
  logic [TIME_W-1:0] tat;
  logic [SUM_W-1:0]  wsum_n;
  logic [SUM_W-1:0]  tsum_n;
  job_rec_t          wr_rec;
  job_rec_t          rd_rec;

  pick_ctl_t         pk_ctl;
  logic              pk_found;
  job_rec_t          pk_rec;
  logic [IDX_W-1:0]  pk_idx;
  logic [ARR_W-1:0]  pk_earliest;

  // Records are taken only between schedules; a finished result may still
  // sit in the output register while the next batch loads.
  assign in_job.ready = (state_r == ST_IDLE);
  assign in_fire      = in_job.valid && in_job.ready;
  assign load_en      = in_fire && (cnt_r < CNT_W'(MAX_JOBS));  // full: drop record

  assign wr_rec.arrival = in_job.arrival_time;
  assign wr_rec.burst   = in_job.burst_time;
  assign wr_rec.prio    = in_job.priority_level;

  // One read per scan cycle, addresses 0..N-1
  assign rd_en   = (state_r == ST_SCAN) && (scan_r < cnt_r);
  assign rd_addr = scan_r[IDX_W-1:0];

  // Last record seen by the picker once the address ran out and the
  // read pipeline drained
  assign scan_end = (state_r == ST_SCAN) && (scan_r == cnt_r) && !rd_vld_r;

  assign emit        = (state_r == ST_EMIT) && (!out_valid_r || out_job.ready);
  assign emitted_inc = emitted_r + 1'b1;
  assign last_job    = (emitted_inc == cnt_r);
  assign num_inc     = {1'b0, pk_idx} + 1'b1;

  // Timing of the chosen job; all values saturate at their field width
  assign tat    = sat_time((TIME_W+1)'(wait_r) + (TIME_W+1)'(pk_rec.burst));
  assign wsum_n = sat_sum((SUM_W+1)'(wsum_r) + (SUM_W+1)'(wait_r));
  assign tsum_n = sat_sum((SUM_W+1)'(tsum_r) + (SUM_W+1)'(tat));

  // Picker restarts on every scan start
  assign pk_ctl.clear  = (in_fire && in_job.last_entry) ||
                         (scan_end && !pk_found) ||
                         (emit && !last_job);
  assign pk_ctl.sample = rd_vld_r;
  assign pk_ctl.skip   = done_r[rd_idx_r];

  nps_job_mem #(
    .DEPTH (MAX_JOBS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  nps_picker #(
    .IDX_W (IDX_W)
  ) u_picker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pk_ctl),
    .clock_now (clock_r),
    .rec       (rd_rec),
    .idx       (rd_idx_r),
    .found     (pk_found),
    .best_rec  (pk_rec),
    .best_idx  (pk_idx),
    .earliest  (pk_earliest)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      emitted_r   <= '0;
      scan_r      <= '0;
      done_r      <= '0;
      clock_r     <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      // A new result refills the register in the cycle the old one leaves
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_job.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (load_en) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_job.last_entry) begin
              state_r <= ST_SCAN;
              scan_r  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_r <= scan_r + 1'b1;
          end
          if (scan_end) begin
            if (pk_found) begin
              state_r <= ST_CALC;
            end else begin
              // Nothing ready: jump to the earliest pending arrival and rescan
              clock_r <= TIME_W'(pk_earliest);
              scan_r  <= '0;
            end
          end
        end
        ST_CALC: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            if (last_job) begin
              // Batch finished: back to the empty state
              state_r   <= ST_IDLE;
              cnt_r     <= '0;
              emitted_r <= '0;
              done_r    <= '0;
              clock_r   <= '0;
              wsum_r    <= '0;
              tsum_r    <= '0;
            end else begin
              state_r        <= ST_SCAN;
              scan_r         <= '0;
              emitted_r      <= emitted_inc;
              done_r[pk_idx] <= 1'b1;
              clock_r        <= cnext_r;
              wsum_r         <= wsum_n;
              tsum_r         <= tsum_n;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    if (state_r == ST_CALC) begin
      wait_r  <= clock_r - TIME_W'(pk_rec.arrival);
      cnext_r <= sat_time((TIME_W+1)'(clock_r) + (TIME_W+1)'(pk_rec.burst));
    end
    if (emit) begin
      out_num_r   <= NUM_W'(num_inc);
      out_start_r <= clock_r;
      out_wait_r  <= wait_r;
      out_tat_r   <= tat;
      out_wsum_r  <= wsum_n;
      out_tsum_r  <= tsum_n;
      out_final_r <= last_job;
    end
  end

  assign out_job.valid            = out_valid_r;
  assign out_job.job_number       = out_num_r;
  assign out_job.start_time       = out_start_r;
  assign out_job.wait_time        = out_wait_r;
  assign out_job.turnaround_time  = out_tat_r;
  assign out_job.total_wait       = out_wsum_r;
  assign out_job.total_turnaround = out_tsum_r;
  assign out_job.final_result     = out_final_r;

  // Checks
  `NPS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(MAX_JOBS), "load count past capacity")
  `NPS_ASSERT_NOW(a_pick_open, state_r == ST_CALC, pk_found && !done_r[pk_idx], "picked done job")
  `NPS_ASSERT_NOW(a_done_cnt, 1'b1, $countones(done_r) == emitted_r, "done flags out of step")
  `NPS_ASSERT_NEXT(a_batch_end, emit && last_job, state_r == ST_IDLE && cnt_r == '0, "batch not cleared")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the non-preemptive priority scheduler. Job records
// are loaded in batches. Each batch is closed by its marked item. A
// behavioral scheduler inside the bench predicts the completion order, the
// start/wait/turnaround times and the running totals. Every completed job is
// checked field by field. Directed batches come first, then random batches
// under several sender/receiver idle mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import nps_pkg::*;

  localparam int MAX_JOBS      = 16;
  localparam int CYCLE_LIMIT   = 500000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 80;      // quiet time for stray completions after the last drain
  localparam int HOLD_CYCLES   = 600;     // long output hold-off
  localparam int PHASE_RECORDS = 78;      // random records per idle mix

  // One completed job as it should leave the block
  typedef struct {
    logic [NUM_W-1:0]  job_number;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [SUM_W-1:0]  total_wait;
    logic [SUM_W-1:0]  total_turnaround;
    logic              final_result;
  } job_result_t;

  logic clk;
  logic rst_n;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS (MAX_JOBS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_job  (in_ch.sink),
    .out_job (out_ch.source)
  );

  // Predicted completions, oldest first
  job_result_t completed_q[$];

  // Records of the batch being loaded (bench-side copy)
  job_rec_t batch_rec[MAX_JOBS];
  int       batch_len = 0;

  // Traffic shaping, in percent per cycle
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_cycles   = 0;

  // Bookkeeping
  int cycle_count     = 0;
  int error_count     = 0;
  int records_sent    = 0;
  int records_dropped = 0;
  int batches_sent    = 0;
  int jobs_checked    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d completed jobs still due",
             cycle_count, completed_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Behavioral scheduler
  // --------------------------------------------------------------------------

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Runs the whole schedule of the loaded batch and queues one expected
  // result per job, in completion order.
  function automatic void schedule_batch();
    logic [MAX_JOBS-1:0] finished;
    longint unsigned     now;
    longint unsigned     earliest;
    longint unsigned     waited;
    longint unsigned     tat;
    longint unsigned     wsum;
    longint unsigned     tsum;
    int                  emitted;
    int                  pick;
    bit                  found;
    job_result_t         res;

    finished = '0;
    now      = 0;
    wsum     = 0;
    tsum     = 0;
    emitted  = 0;
    while (emitted < batch_len) begin
      found    = 1'b0;
      pick     = 0;
      earliest = '1;
      // Scan in load order: a later job only wins on a strictly lower
      // priority value or, at equal priority, a strictly earlier arrival,
      // so full ties stay with the lower job number.
      for (int i = 0; i < batch_len; i++) begin
        if (!finished[i]) begin
          if (batch_rec[i].arrival < earliest) earliest = batch_rec[i].arrival;
          if (batch_rec[i].arrival <= now &&
              (!found || batch_rec[i].prio < batch_rec[pick].prio ||
               (batch_rec[i].prio == batch_rec[pick].prio &&
                batch_rec[i].arrival < batch_rec[pick].arrival))) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        // CPU idle: time jumps to the next pending arrival
        now = earliest;
      end else begin
        waited = now - batch_rec[pick].arrival;
        tat    = clamp(waited + batch_rec[pick].burst, 64'(TIME_MAX));
        wsum   = clamp(wsum + waited, 64'(SUM_MAX));
        tsum   = clamp(tsum + tat, 64'(SUM_MAX));
        finished[pick] = 1'b1;

        res.job_number       = NUM_W'(pick + 1);
        res.start_time       = TIME_W'(now);
        res.wait_time        = TIME_W'(waited);
        res.turnaround_time  = TIME_W'(tat);
        res.total_wait       = SUM_W'(wsum);
        res.total_turnaround = SUM_W'(tsum);
        res.final_result     = (emitted + 1 == batch_len);
        completed_q.push_back(res);

        now = clamp(now + batch_rec[pick].burst, 64'(TIME_MAX));
        emitted++;
      end
    end
  endfunction

  // Accepted record: store it unless the batch is full; the marked item
  // closes the batch even when its own record is dropped.
  function automatic void note_record(job_rec_t rec, logic last);
    if (batch_len < MAX_JOBS) begin
      batch_rec[batch_len] = rec;
      batch_len++;
    end else begin
      records_dropped++;
    end
    if (last) begin
      schedule_batch();
      batch_len = 0;
      batches_sent++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Receiver ready: random stalls, or a counted hold-off when one is armed
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare each accepted completion against the oldest prediction
  always @(posedge clk) begin : check_results
    job_result_t want;

    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (completed_q.size() == 0) begin
        $error("unexpected completed job %0d at cycle %0d",
               out_ch.job_number, cycle_count);
        error_count++;
      end else begin
        want = completed_q.pop_front();
        if (out_ch.job_number !== want.job_number) begin
          $error("job_number: expected %0d, got %0d",
                 want.job_number, out_ch.job_number);
          error_count++;
        end
        if (out_ch.start_time !== want.start_time) begin
          $error("start_time: expected %0d, got %0d",
                 want.start_time, out_ch.start_time);
          error_count++;
        end
        if (out_ch.wait_time !== want.wait_time) begin
          $error("wait_time: expected %0d, got %0d",
                 want.wait_time, out_ch.wait_time);
          error_count++;
        end
        if (out_ch.turnaround_time !== want.turnaround_time) begin
          $error("turnaround_time: expected %0d, got %0d",
                 want.turnaround_time, out_ch.turnaround_time);
          error_count++;
        end
        if (out_ch.total_wait !== want.total_wait) begin
          $error("total_wait: expected %0d, got %0d",
                 want.total_wait, out_ch.total_wait);
          error_count++;
        end
        if (out_ch.total_turnaround !== want.total_turnaround) begin
          $error("total_turnaround: expected %0d, got %0d",
                 want.total_turnaround, out_ch.total_turnaround);
          error_count++;
        end
        if (out_ch.final_result !== want.final_result) begin
          $error("final_result: expected %0d, got %0d",
                 want.final_result, out_ch.final_result);
          error_count++;
        end
        jobs_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one record and hold it until the handshake. Valid stays high on
  // return, so the caller either offers the next item or parks the channel
  // (random idle or drain) in the step of the acceptance.
  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                          input logic [PRI_W-1:0] pri, input logic last);
    job_rec_t rec;

    rec.arrival = arr;
    rec.burst   = bur;
    rec.prio    = pri;
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.arrival_time   <= arr;
    in_ch.burst_time     <= bur;
    in_ch.priority_level <= pri;
    in_ch.last_entry     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    records_sent++;
    note_record(rec, last);
  endtask

  // Park the input and wait until every predicted completion has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (completed_q.size() != 0) @(posedge clk);
  endtask

  // One well-formed batch with random content. Most batches are short;
  // some fill the store exactly, some run past it so that records drop.
  task automatic send_random_batch();
    int               size;
    int               arr_mode;
    bit               short_burst;
    bit               narrow_prio;
    logic [ARR_W-1:0] base;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;

    case ($urandom_range(9))
      0:       size = MAX_JOBS;
      1:       size = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
      default: size = $urandom_range(8, 1);
    endcase
    arr_mode    = $urandom_range(2);
    base        = ARR_W'($urandom);
    short_burst = ($urandom_range(1) != 0);
    narrow_prio = ($urandom_range(1) != 0);
    for (int k = 0; k < size; k++) begin
      // dense arrivals give contention, wide ones give idle jumps
      case (arr_mode)
        0:       arr = ARR_W'($urandom_range(40));
        1:       arr = ARR_W'($urandom);
        default: arr = base + ARR_W'($urandom_range(200));
      endcase
      bur = short_burst ? BUR_W'($urandom_range(20)) : BUR_W'($urandom);
      pri = narrow_prio ? PRI_W'($urandom_range(3)) : PRI_W'($urandom);
      send_job(arr, bur, pri, k == size - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Single-job batches at the top and bottom of every field
  task automatic test_extremes();
    send_job('1, '1, '1, 1'b1);
    send_job('0, '0, '0, 1'b1);
    drain();
  endtask

  // Nothing ready at time 0, jump to 2; jobs 2 and 3 tie fully (load order
  // wins); job 4 later beats jobs 1 and 3 on priority; jobs 1 and 3 then tie
  // on priority and job 3 wins on its earlier arrival.
  task automatic test_tie_break();
    send_job(16'd5, 16'd3, 8'd3, 1'b0);
    send_job(16'd2, 16'd4, 8'd3, 1'b0);
    send_job(16'd2, 16'd1, 8'd3, 1'b0);
    send_job(16'd3, 16'd2, 8'd1, 1'b1);
    drain();
  endtask

  // CPU goes idle between the two jobs
  task automatic test_idle_jump();
    send_job(16'd100, 16'd10, 8'd0, 1'b0);
    send_job(16'd500, 16'd1,  8'd0, 1'b1);
    drain();
  endtask

  // Full store of maximum-length jobs, then two records past capacity:
  // an unmarked one and a marked one, both dropped, the mark still closing
  // the batch.
  task automatic test_capacity_overflow();
    for (int k = 0; k < MAX_JOBS; k++) send_job('1, '1, PRI_W'(k % 3), 1'b0);
    send_job('0, '0, '0, 1'b0);
    send_job('1, '1, '1, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int first;

    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    first         = records_sent;
    while (records_sent - first < PHASE_RECORDS) send_random_batch();
    drain();
  endtask

  // Output held off for a long stretch while the sender keeps going, so the
  // block backs up and must stall its input.
  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    @(posedge clk);
    hold_cycles <= HOLD_CYCLES;
    repeat (3) send_random_batch();
    drain();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.arrival_time   = '0;
    in_ch.burst_time     = '0;
    in_ch.priority_level = '0;
    in_ch.last_entry     = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_tie_break();
    test_idle_jump();
    test_capacity_overflow();
    test_random_traffic(0, 0);
    test_random_traffic(71, 0);
    test_random_traffic(0, 71);
    test_random_traffic(6, 6);
    test_backpressure();

    // catch stray completions after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (completed_q.size() != 0) begin
      $error("%0d completed jobs never arrived", completed_q.size());
      error_count++;
    end

    $display("summary: %0d job records in %0d batches, %0d dropped past capacity",
             records_sent, batches_sent, records_dropped);
    $display("summary: %0d completed jobs checked over four idle mixes and a long hold-off",
             jobs_checked);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_in_if.sv
rtl/nps_out_if.sv
rtl/nps_job_mem.sv
rtl/nps_picker.sv
rtl/nonpreemptive_priority_scheduler.sv
tb/tb_top.sv
